>>> design/fifo_demand_paging_policy_defines.svh
// Assertion macros used by the paging policy back end
`ifndef FIFO_DEMAND_PAGING_POLICY_DEFINES_SVH
`define FIFO_DEMAND_PAGING_POLICY_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define FPP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("paging policy check failed");

// Next-cycle implication, checked outside reset
`define FPP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("paging policy check failed");

`endif

>>> design/fpp_pkg.sv
// Types and constants of the FIFO demand-paging policy
package fpp_pkg;

    localparam int PAGES_DEF = 32;
    localparam int SLOTS_DEF = 32;

    localparam logic [1:0] ACT_FAULT = 2'd0;
    localparam logic [1:0] ACT_REG   = 2'd1;
    localparam logic [1:0] ACT_LIMIT = 2'd2;

    typedef enum logic [3:0] {
        K_SEGV      = 4'd0,
        K_DROP      = 4'd1,
        K_WR_BACK   = 4'd2,
        K_WR_SWAP   = 4'd3,
        K_LD_ZERO   = 4'd4,
        K_LD_BACK   = 4'd5,
        K_LD_SWAP   = 4'd6,
        K_GRANT     = 4'd7,
        K_REGD      = 4'd8,
        K_LIMIT_SET = 4'd9
    } kind_t;

    typedef enum logic [1:0] {
        OP_FAULT = 2'd0,
        OP_REG   = 2'd1,
        OP_LIMIT = 2'd2,
        OP_BAD   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_RUN     = 3'd1,
        S_EVICT   = 3'd2,
        S_LOAD    = 3'd3,
        S_LIM_END = 3'd4
    } bstate_t;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] page;
        logic       backed;
        logic [5:0] new_limit;
    } cmd_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [4:0] page_res;
        logic [4:0] swap_slot;
        logic       last;
    } res_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] page;
        logic       backed;
        logic [5:0] new_limit;
    } op_item_t;

endpackage

>>> design/fpp_front.sv
// Command intake: classifies each command and queues all but the unused action code for the back end
module fpp_front #(
    parameter int PAGES = fpp_pkg::PAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  fpp_pkg::cmd_t      req,
    output logic               q_valid,
    output fpp_pkg::op_item_t  q_item,
    input  logic               q_pop
);
    import fpp_pkg::*;

    op_item_t   ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    op_item_t   cls;
    logic       push;

    always_comb
    begin
        cls.page      = req.page;
        cls.backed    = req.backed;
        cls.new_limit = req.new_limit;
        unique case (req.action)
            ACT_FAULT, ACT_REG:
            begin
                if ({1'b0, req.page} >= 6'(PAGES))
                    cls.op = OP_BAD;
                else if (req.action == ACT_FAULT)
                    cls.op = OP_FAULT;
                else
                    cls.op = OP_REG;
            end
            ACT_LIMIT: cls.op = OP_LIMIT;
            default:   cls.op = OP_BAD;
        endcase
    end

    assign busy    = (cnt_reg == 2'd2);
    // drop the unused action code here: it has no result
    assign push    = start && !busy && (req.action != 2'd3);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= cls;
    end

endmodule

>>> design/fpp_back.sv
// Policy engine: page tables, FIFO order, swap allocation and results
module fpp_back #(
    parameter int PAGES      = fpp_pkg::PAGES_DEF,
    parameter int SWAP_SLOTS = fpp_pkg::SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  fpp_pkg::op_item_t  q_item,
    output logic               q_pop,
    output logic               valid,
    output fpp_pkg::res_t      result
);
    import fpp_pkg::*;
    `include "fifo_demand_paging_policy_defines.svh"

    localparam int PW = $clog2(PAGES);
    localparam int SW = $clog2(SWAP_SLOTS);
    localparam int CW = $clog2(PAGES + 1);

    bstate_t         state_reg, state_next;
    op_item_t        op_reg;
    logic [PAGES-1:0] valid_reg, valid_next;
    logic [PAGES-1:0] present_reg, present_next;
    logic [PAGES-1:0] dirty_reg, dirty_next;
    logic [PAGES-1:0] backed_reg, backed_next;
    logic [PAGES-1:0] in_swap_reg, in_swap_next;
    logic [SWAP_SLOTS-1:0] busy_reg, busy_next;
    logic [SW-1:0]   slot_reg [PAGES];
    logic [PW-1:0]   fifo_reg [PAGES];
    logic [PW-1:0]   head_reg, head_next;
    logic [PW-1:0]   tail_reg, tail_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   limit_reg, limit_next;
    res_t            res_reg, res_next;
    logic            vld_reg, vld_next;

    logic [PW-1:0]   pidx;
    logic [PW-1:0]   victim;
    logic [SW-1:0]   free_slot;
    logic            free_found;
    logic [5:0]      lim;
    logic            lim_lower;
    logic            must_evict;
    logic            more_evict;
    logic            slot_we;
    logic            fifo_we;

    assign pidx   = PW'(op_reg.page);
    assign victim = fifo_reg[head_reg];
    assign lim    = (op_reg.new_limit == 6'd0) ? 6'd1 : op_reg.new_limit;
    assign lim_lower  = {1'b0, lim} < 7'(limit_reg);
    assign must_evict = (count_reg >= limit_reg) && (count_reg != '0);
    assign more_evict = (7'(count_reg) - 7'd1) > 7'(limit_reg);
    assign q_pop  = (state_reg == S_IDLE) && q_valid;

    // lowest free swap slot
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = SWAP_SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SW'(i);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (q_valid)
                    state_next = S_RUN;
            S_RUN:
            begin
                unique case (op_reg.op)
                    OP_FAULT:
                        if (!valid_reg[pidx] || present_reg[pidx])
                            state_next = S_IDLE;
                        else if (must_evict)
                            state_next = S_EVICT;
                        else
                            state_next = S_LOAD;
                    OP_LIMIT:
                        if (lim_lower && (7'(count_reg) > {1'b0, lim}))
                            state_next = S_EVICT;
                        else
                            state_next = S_IDLE;
                    default: state_next = S_IDLE;
                endcase
            end
            S_EVICT:
                if (op_reg.op == OP_FAULT)
                    state_next = S_LOAD;
                else if (!more_evict)
                    state_next = S_LIM_END;
            S_LOAD:    state_next = S_IDLE;
            S_LIM_END: state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // results
    always_comb
    begin
        vld_next           = 1'b0;
        res_next.kind      = K_SEGV;
        res_next.page_res  = op_reg.page;
        res_next.swap_slot = 5'd0;
        res_next.last      = 1'b1;
        unique case (state_reg)
            S_RUN:
            begin
                unique case (op_reg.op)
                    OP_FAULT:
                    begin
                        vld_next = !valid_reg[pidx] || present_reg[pidx];
                        res_next.kind = valid_reg[pidx] ? K_GRANT : K_SEGV;
                    end
                    OP_REG:
                    begin
                        vld_next      = 1'b1;
                        res_next.kind = K_REGD;
                    end
                    OP_LIMIT:
                    begin
                        vld_next = !(lim_lower && (7'(count_reg) > {1'b0, lim}));
                        res_next.kind     = K_LIMIT_SET;
                        res_next.page_res = 5'd0;
                    end
                    default:
                    begin
                        vld_next      = 1'b1;
                        res_next.kind = K_SEGV;
                    end
                endcase
            end
            S_EVICT:
            begin
                vld_next          = 1'b1;
                res_next.last     = 1'b0;
                res_next.page_res = 5'(victim);
                if (!dirty_reg[victim])
                    res_next.kind = K_DROP;
                else if (backed_reg[victim])
                    res_next.kind = K_WR_BACK;
                else if (free_found)
                begin
                    res_next.kind      = K_WR_SWAP;
                    res_next.swap_slot = 5'(free_slot);
                end
                else
                    res_next.kind = K_DROP;
            end
            S_LOAD:
            begin
                vld_next = 1'b1;
                if (in_swap_reg[pidx])
                begin
                    res_next.kind      = K_LD_SWAP;
                    res_next.swap_slot = 5'(slot_reg[pidx]);
                end
                else if (backed_reg[pidx])
                    res_next.kind = K_LD_BACK;
                else
                    res_next.kind = K_LD_ZERO;
            end
            S_LIM_END:
            begin
                vld_next          = 1'b1;
                res_next.kind     = K_LIMIT_SET;
                res_next.page_res = 5'd0;
            end
            default: vld_next = 1'b0;
        endcase
    end

    // page tables and FIFO order
    always_comb
    begin
        valid_next   = valid_reg;
        present_next = present_reg;
        dirty_next   = dirty_reg;
        backed_next  = backed_reg;
        in_swap_next = in_swap_reg;
        busy_next    = busy_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        limit_next   = limit_reg;
        slot_we      = 1'b0;
        fifo_we      = 1'b0;
        unique case (state_reg)
            S_RUN:
            begin
                if (op_reg.op == OP_REG && !valid_reg[pidx])
                begin
                    valid_next[pidx]   = 1'b1;
                    backed_next[pidx]  = op_reg.backed;
                    present_next[pidx] = 1'b0;
                    dirty_next[pidx]   = 1'b0;
                    in_swap_next[pidx] = 1'b0;
                end
                if (op_reg.op == OP_FAULT && valid_reg[pidx] && present_reg[pidx])
                    dirty_next[pidx] = 1'b1;
                if (op_reg.op == OP_LIMIT && lim_lower)
                    limit_next = CW'(lim);
            end
            S_EVICT:
            begin
                head_next = (32'(head_reg) == PAGES - 1) ? '0 : head_reg + 1'b1;
                count_next = count_reg - 1'b1;
                present_next[victim] = 1'b0;
                dirty_next[victim]   = 1'b0;
                if (dirty_reg[victim] && !backed_reg[victim] && free_found)
                begin
                    busy_next[free_slot] = 1'b1;
                    in_swap_next[victim] = 1'b1;
                    slot_we              = 1'b1;
                end
            end
            S_LOAD:
            begin
                if (in_swap_reg[pidx])
                begin
                    busy_next[slot_reg[pidx]] = 1'b0;
                    in_swap_next[pidx]        = 1'b0;
                    dirty_next[pidx]          = 1'b1;
                end
                present_next[pidx] = 1'b1;
                fifo_we   = 1'b1;
                tail_next = (32'(tail_reg) == PAGES - 1) ? '0 : tail_reg + 1'b1;
                count_next = count_reg + 1'b1;
            end
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            present_reg <= '0;
            dirty_reg   <= '0;
            backed_reg  <= '0;
            in_swap_reg <= '0;
            busy_reg    <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            limit_reg   <= CW'(PAGES);
            vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            present_reg <= present_next;
            dirty_reg   <= dirty_next;
            backed_reg  <= backed_next;
            in_swap_reg <= in_swap_next;
            busy_reg    <= busy_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            limit_reg   <= limit_next;
            vld_reg     <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (q_pop)
            op_reg <= q_item;
        if (slot_we)
            slot_reg[victim] <= free_slot;
        if (fifo_we)
            fifo_reg[tail_reg] <= pidx;
    end

    assign valid  = vld_reg;
    assign result = res_reg;

    `FPP_ASSERT_IMP(a_last_idle, vld_reg && res_reg.last, state_reg == S_IDLE)
    `FPP_ASSERT_IMP(a_evict_nonempty, state_reg == S_EVICT, count_reg != '0)
    `FPP_ASSERT_IMP(a_count_fits, 1'b1, 32'(count_reg) <= PAGES)
    `FPP_ASSERT_NXT(a_load_grows, state_reg == S_LOAD, count_reg == $past(count_reg) + 1'b1)

endmodule

>>> design/fifo_demand_paging_policy.sv
// FIFO demand-paging policy: top level
// Usage:
// A command is transferred at a rising edge where start is high and busy is
// low; req carries action, page, backed and new_limit. Busy rises only when
// the two-entry command queue is full, so a further command may be issued
// while the engine is still working on an earlier one.
// Each result appears on result for one cycle with valid high and must be
// taken then: the receiver cannot stall. The final result of a command has
// result.last set; an unused action code yields no result at all.
// A fault on a resident or unregistered page, a registration and a limit
// change that evicts nothing give one result; a fault that loads gives a load
// result, preceded by an eviction result when the resident limit is reached;
// lowering the limit gives one result per evicted page, then a final one.
// The engine's sequencer handles one command at a time: when idle it fetches
// the next command from the queue, then steps through the run state and, as
// needed, the evict, load or limit-end states, one table step per cycle.
// Reset clears all page state, the FIFO order and the queue, and restores the
// resident limit to the full page count; no clearing pass is needed.
module fifo_demand_paging_policy #(
    parameter int PAGES      = fpp_pkg::PAGES_DEF,
    parameter int SWAP_SLOTS = fpp_pkg::SLOTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  fpp_pkg::cmd_t  req,
    output logic           valid,
    output fpp_pkg::res_t  result
);
    import fpp_pkg::*;

    logic     q_valid;
    logic     q_pop;
    op_item_t q_item;

    fpp_front #(
        .PAGES(PAGES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    fpp_back #(
        .PAGES     (PAGES),
        .SWAP_SLOTS(SWAP_SLOTS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .valid   (valid),
        .result  (result)
    );

endmodule
